[sv/lkvc_pkg.sv]
// Package: widths and constants for the LRU key-value cache.
`default_nettype none
package lkvc_pkg;
  localparam int unsigned Entries = 64;
  localparam int unsigned SlotW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 7;
  localparam logic [CapW-1:0] CapReset = CapW'(64);
  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [ValW-1:0] read_value;
  } rsp_t;
endpackage
`default_nettype wire

[sv/lkvc_req_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface lkvc_req_if import lkvc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/lru_key_value_cache_unit.sv]
// Top level: LRU key-value cache with a sequential memory scan.
// A hit scans to its slot, then runs StRdVal, StHit and, unless the slot is
// newest, StUnl, StUnl2, StLink; a miss scans all slots to StRdOld, and a put
// then runs StEvRd, StEvict, StFree if it evicts, then StIns. All end in
// StDone. The scan reads one key slot per cycle. Throughput: one request at a
// time; the next is accepted after the response is taken. Reset clears valid
// bits, list pointers and count at once; memories are not cleared.
`default_nettype none
module lru_key_value_cache_unit import lkvc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CapW-1:0] cfg_wdata_i,
  lkvc_req_if.sink             req,
  lkvc_rsp_if.source           rsp
);
  typedef enum logic [3:0] {
    StIdle, StScan, StRdVal, StHit, StUnl, StUnl2, StLink, StRdOld, StEvRd, StEvict,
    StFree, StIns, StDone
  } state_e;

  logic [KeyW-1:0] key_mem [Entries];
  logic [ValW-1:0] val_mem [Entries];
  logic [SlotW-1:0] newer_mem [Entries];
  logic [SlotW-1:0] older_mem [Entries];

  state_e state_q;
  logic [Entries-1:0] valid_q;
  logic [SlotW-1:0] newest_q, oldest_q, slot_q, nw_q, od_q;
  logic [CntW-1:0] count_q;
  logic [CapW-1:0] cap_q;
  req_t req_q;
  logic [CntW-1:0] scan_q;
  logic hit_q;
  logic rsp_valid_q;
  rsp_t rsp_q;

  logic [KeyW-1:0] key_rd;
  logic [ValW-1:0] val_rd;
  logic [SlotW-1:0] newer_rd, older_rd;
  logic [SlotW-1:0] rd_addr;

  logic [CntW-1:0] cap_eff;
  always_comb begin
    if (cap_q == '0) cap_eff = CntW'(1);
    else if ({1'b0, cap_q} > (CapW+1)'(Entries)) cap_eff = CntW'(Entries);
    else cap_eff = CntW'(cap_q);
  end

  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = SlotW'(i);
    end
  end

  always_comb begin
    rd_addr = slot_q;
    if (state_q == StScan) rd_addr = scan_q[SlotW-1:0];
  end

  // Memory write port (single per memory, issued by the sequencer).
  logic            kw_en, vw_en, nw_en, ow_en;
  logic [SlotW-1:0] kw_a, vw_a, nw_a, ow_a, nw_d, ow_d;
  logic [ValW-1:0] vw_d;

  always_ff @(posedge clk_i) begin
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
    newer_rd <= newer_mem[rd_addr];
    older_rd <= older_mem[rd_addr];
    if (kw_en) key_mem[kw_a] <= req_q.key;
    if (vw_en) val_mem[vw_a] <= vw_d;
    if (nw_en) newer_mem[nw_a] <= nw_d;
    if (ow_en) older_mem[ow_a] <= ow_d;
  end

  assign req.ready = (state_q == StIdle) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data = rsp_q;

  logic [SlotW-1:0] scan_prev;
  assign scan_prev = scan_q[SlotW-1:0] - SlotW'(1);

  always_comb begin
    kw_en = 1'b0; vw_en = 1'b0; nw_en = 1'b0; ow_en = 1'b0;
    kw_a = slot_q; vw_a = slot_q; nw_a = slot_q; ow_a = slot_q;
    nw_d = slot_q; ow_d = newest_q; vw_d = req_q.value;
    unique case (state_q)
      StHit: vw_en = hit_q && (req_q.mode == ModePut);
      StUnl: if (slot_q != oldest_q) begin
        nw_en = 1'b1; nw_a = od_q; nw_d = nw_q;
      end
      StUnl2: if (slot_q != oldest_q) begin
        ow_en = 1'b1; ow_a = nw_q; ow_d = od_q;
      end
      StLink: begin
        nw_en = 1'b1; nw_a = newest_q; nw_d = slot_q;
        ow_en = 1'b1; ow_a = slot_q; ow_d = newest_q;
      end
      StIns: begin
        kw_en = 1'b1; vw_en = 1'b1;
        if (count_q != '0) begin
          nw_en = 1'b1; nw_a = newest_q; nw_d = slot_q;
          ow_en = 1'b1; ow_a = slot_q; ow_d = newest_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      count_q <= '0;
      cap_q <= CapReset;
      rsp_valid_q <= 1'b0;
      scan_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (req.valid && req.ready) begin
          req_q <= req.data;
          scan_q <= '0;
          hit_q <= 1'b0;
          state_q <= StScan;
        end
        StScan: begin
          // key_rd holds slot scan_q-1 once scan_q > 0
          if (scan_q != '0 && valid_q[scan_prev] && key_rd == req_q.key) begin
            hit_q <= 1'b1;
            slot_q <= scan_prev;
            state_q <= StRdVal;
          end else if (scan_q == CntW'(Entries)) begin
            state_q <= StRdOld;
          end else begin
            scan_q <= scan_q + CntW'(1);
          end
        end
        StRdVal: state_q <= StHit;
        StHit: begin
          rsp_q.found <= 1'b1;
          rsp_q.read_value <= (req_q.mode == ModeGet) ? val_rd : '0;
          nw_q <= newer_rd;
          od_q <= older_rd;
          if (slot_q == newest_q) state_q <= StDone;
          else state_q <= StUnl;
        end
        StUnl: state_q <= StUnl2;
        StUnl2: begin
          if (slot_q == oldest_q) oldest_q <= nw_q;
          state_q <= StLink;
        end
        StLink: begin
          newest_q <= slot_q;
          state_q <= StDone;
        end
        StRdOld: begin
          rsp_q.found <= 1'b0;
          rsp_q.read_value <= '0;
          if (req_q.mode == ModeGet) state_q <= StDone;
          else if (count_q + CntW'(1) > cap_eff && count_q != '0) begin
            slot_q <= oldest_q;
            state_q <= StEvRd;
          end else begin
            slot_q <= free_slot;
            state_q <= StIns;
          end
        end
        StEvRd: state_q <= StEvict;
        StEvict: begin
          // newer link of the oldest slot was read in StEvRd
          if (count_q != CntW'(1)) oldest_q <= newer_rd;
          valid_q[slot_q] <= 1'b0;
          count_q <= count_q - CntW'(1);
          state_q <= StFree;
        end
        StFree: begin
          slot_q <= free_slot;
          state_q <= StIns;
        end
        StIns: begin
          valid_q[slot_q] <= 1'b1;
          newest_q <= slot_q;
          if (count_q == '0) oldest_q <= slot_q;
          count_q <= count_q + CntW'(1);
          state_q <= StDone;
        end
        StDone: begin
          rsp_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Entries)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q)) else $error("valid count mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !req.ready) else $error("accepted while response pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIns) |-> !valid_q[slot_q]) else $error("insert over live slot");
endmodule
`default_nettype wire

[sim/tb_lru_key_value_cache_unit.sv]
// Testbench: random and directed requests against an LRU cache predictor.
module tb_lru_key_value_cache_unit;
  import lkvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;

  lkvc_req_if req ();
  lkvc_rsp_if rsp ();

  lru_key_value_cache_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state: slots kept in recency order, index 0 is the newest
  logic [KeyW-1:0] lru_keys[$];
  logic [ValW-1:0] lru_vals[$];
  int unsigned cap_setting = 64;
  rsp_t expected_rsps[$];
  int errors = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit stall_en = 1'b1;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic rsp_t predict_lookup(input req_t r);
    rsp_t o;
    int hit;
    int cap;
    logic [KeyW-1:0] k;
    logic [ValW-1:0] v;
    o = '0;
    hit = -1;
    foreach (lru_keys[i]) if (hit < 0 && lru_keys[i] == r.key) hit = i;
    o.found = (hit >= 0);
    if (hit >= 0) begin
      k = lru_keys[hit];
      v = lru_vals[hit];
      if (r.mode == ModeGet) o.read_value = v;
      else v = r.value;
      lru_keys.delete(hit);
      lru_vals.delete(hit);
      lru_keys.push_front(k);
      lru_vals.push_front(v);
      return o;
    end
    if (r.mode == ModeGet) return o;
    cap = (cap_setting == 0) ? 1 : (cap_setting > Entries ? Entries : cap_setting);
    if (lru_keys.size() + 1 > cap && lru_keys.size() > 0) begin
      void'(lru_keys.pop_back());
      void'(lru_vals.pop_back());
    end
    lru_keys.push_front(r.key);
    lru_vals.push_front(r.value);
    return o;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_lru_key_value_cache_unit failed");
      $finish;
    end
  end

  // response check
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) report("response with nothing expected");
      else begin
        e = expected_rsps.pop_front();
        if (rsp.data.found !== e.found)
          report($sformatf("found %0b exp %0b", rsp.data.found, e.found));
        if (rsp.data.read_value !== e.read_value)
          report($sformatf("value %h exp %h", rsp.data.read_value, e.read_value));
      end
    end
  end

  // receiver stall pattern and long hold-off
  initial rsp.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      rsp.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!stall_en) rsp.ready <= 1'b1;
    else rsp.ready <= (cycles % 16 < 11) ? ($urandom_range(0, 3) != 0) : 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.data = '0;
  end

  int burst_left = 0;

  task automatic send_request(input logic mode, input logic [KeyW-1:0] key,
                              input logic [ValW-1:0] value);
    req_t r;
    r.mode = mode;
    r.key = key;
    r.value = value;
    if (stall_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end
      burst_left--;
    end
    req.valid = 1'b1;
    req.data = r;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    expected_rsps.push_back(predict_lookup(r));
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (Entries + 20) @(negedge clk_i);
  endtask

  task automatic set_capacity(input int unsigned c);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c[CapW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_setting = c;
  endtask

  function automatic logic [KeyW-1:0] pick_key(input int pool);
    return ($urandom_range(0, 9) == 0) ? KeyW'($urandom) : KeyW'($urandom_range(0, pool));
  endfunction

  task automatic test_directed();
    send_request(ModeGet, '1, '1);
    send_request(ModePut, '1, '1);
    send_request(ModeGet, '1, '0);
    send_request(ModePut, '0, '0);
    send_request(ModePut, '0, 32'h5555_aaaa);
    send_request(ModeGet, '0, '0);
    send_request(ModePut, 31'h2aaa_aaaa, 32'haaaa_5555);
    send_request(ModeGet, 31'h2aaa_aaaa, '1);
    send_request(ModeGet, 31'h1234, '0);
  endtask

  task automatic test_small_capacity();
    set_capacity(0);
    send_request(ModePut, 1, 11);
    send_request(ModePut, 2, 22);
    send_request(ModeGet, 1, 0);
    send_request(ModeGet, 2, 0);
    set_capacity(3);
    for (int i = 0; i < 5; i++) send_request(ModePut, KeyW'(10 + i), ValW'(i));
    send_request(ModeGet, 11, 0);
    send_request(ModeGet, 12, 0);
    send_request(ModePut, 20, 7);
    for (int i = 10; i < 15; i++) send_request(ModeGet, KeyW'(i), 0);
  endtask

  task automatic test_lowered_capacity();
    set_capacity(64);
    for (int i = 0; i < 64; i++) send_request(ModePut, KeyW'(100 + i), $urandom);
    send_request(ModePut, 500, 1);
    set_capacity(127);
    send_request(ModePut, 501, 2);
    set_capacity(4);
    send_request(ModePut, 502, 3);
    for (int i = 0; i < 8; i++) send_request(ModeGet, KeyW'(158 + i), 0);
  endtask

  task automatic test_random(input int n, input int pool);
    for (int i = 0; i < n; i++)
      send_request($urandom_range(0, 2) != 0 ? ModePut : ModeGet, pick_key(pool), $urandom);
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 300;
    stall_en = 1'b0;
    for (int i = 0; i < 10; i++) send_request(ModePut, pick_key(20), $urandom);
    stall_en = 1'b1;
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_small_capacity();
    test_lowered_capacity();
    set_capacity(8);
    test_random(120, 15);
    test_backpressure();
    set_capacity(64);
    test_random(90, 80);
    set_capacity(1);
    test_random(30, 3);
    set_capacity(20);
    test_random(100, 30);
    drain();
    if (errors == 0) $display("tb_lru_key_value_cache_unit passed");
    else $display("tb_lru_key_value_cache_unit failed");
    $finish;
  end
endmodule

[sim.f]
sv/lkvc_pkg.sv
sv/lkvc_req_if.sv
sv/lru_key_value_cache_unit.sv
sim/tb_lru_key_value_cache_unit.sv
